/* hw/rtl/svd_pkg.sv */
package svd_pkg;

	// defaults for the top-level parameters
	localparam int SINE_TABLE_BITS_DEF = 10;
	localparam int ANGLE_BITS_DEF      = 16;

	// register map, index = byte address / 4
	localparam int         PADDR_W     = 3;
	localparam logic       REG_GAIN    = 1'b0;
	localparam logic       REG_PERIOD  = 1'b1;
	localparam logic [23:0] GAIN_RST   = 24'd9155;
	localparam logic [15:0] PERIOD_RST = 16'd280;

	// datapath widths
	localparam int AB_W = 34;   // alpha, beta (volt * Q15)
	localparam int KA_W = 50;   // 28378 * alpha
	localparam int D_W  = 35;   // ka - beta/2 and -ka - beta/2
	localparam int G_W  = 25;   // gain with a zero sign bit
	localparam int P_W  = 60;   // beta or difference * gain
	localparam int U_W  = 44;   // u1..u3 after >> 16
	localparam int T_W  = 44;   // active times before scaling
	localparam int DV_W = 45;   // divider remainder
	localparam int Q_W  = 16;   // scaled time, up to one full period

	localparam logic signed [15:0] SQRT3_HALF_Q15 = 16'sd28378;
	localparam logic [16:0]        ONE_Q15        = 17'd32768;
	localparam logic [16:0]        HALF_Q15       = 17'd16384;

	// pipeline latency from accepted start to result strobe
	localparam int LAT = 27;

	localparam logic [2:0] SECT_NONE = 3'd0;
	localparam logic [2:0] SECT_1    = 3'd1;
	localparam logic [2:0] SECT_2    = 3'd2;
	localparam logic [2:0] SECT_3    = 3'd3;
	localparam logic [2:0] SECT_4    = 3'd4;
	localparam logic [2:0] SECT_5    = 3'd5;
	localparam logic [2:0] SECT_6    = 3'd6;

	typedef struct packed {
		logic signed [15:0] voltage_q;
		logic signed [15:0] voltage_d;
		logic [15:0]        electrical_angle;
	} cmd_t;

	typedef struct packed {
		logic [15:0] compare_a;
		logic [15:0] compare_b;
		logic [15:0] compare_c;
		logic [2:0]  sector_number;
		logic        overmodulated;
	} res_t;

	// side data that rides along the divider
	typedef struct packed {
		logic [2:0]     sec;
		logic           ovm;
		logic [Q_W-1:0] tx;
		logic [Q_W-1:0] ty;
	} side_t;

	// quarter-wave sine, Q15, saturated
	function automatic logic [14:0] sine_q15(input int unsigned pos, input int unsigned qb);
		longint x;
		longint x2;
		longint y;
		x  = longint'(pos) << (15 - qb);
		x2 = (x * x) >> 15;
		y  = (x * (51472 - ((x2 * (21024 - ((x2 * 2320) >> 15))) >> 15))) >> 15;
		if (y > 32767) begin
			y = 32767;
		end
		return y[14:0];
	endfunction

endpackage

/* hw/rtl/svpwm_duty_generator_core.sv */
// Channel   | Handshake            | Payload          | Beat
// ----------+----------------------+------------------+-------------------------------
// command   | start / busy         | cmd (cmd_t)      | start high while busy low
// result    | done                 | res (res_t)      | done high for one cycle
// config    | psel/penable/pwrite  | paddr/pwdata     | write at access with pready
//
// One command beat per cycle; busy is never raised.
// Results leave in the order of their command beats.
// The 16-stage restoring divider does the overmodulation scaling.
// Reset clears all valid bits and loads register defaults; no clearing pass.
// The receiver cannot stall, so nothing in the pipe ever waits.
module svpwm_duty_generator_core #(
	parameter int SINE_TABLE_BITS = svd_pkg::SINE_TABLE_BITS_DEF,
	parameter int ANGLE_BITS      = svd_pkg::ANGLE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  svd_pkg::cmd_t               cmd,
	output logic                        done,
	output svd_pkg::res_t               res,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [svd_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import svd_pkg::*;

	logic [23:0] gain;
	logic [15:0] period;

	assign busy   = 1'b0;
	assign pready = 1'b1;

	svd_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.gain   (gain),
		.period (period)
	);

	// s1: sine/cos table read
	logic               v_s1;
	logic signed [15:0] vq_s1;
	logic signed [15:0] vd_s1;
	logic signed [15:0] sin_v;
	logic signed [15:0] cos_v;

	svd_sine #(
		.SINE_TABLE_BITS(SINE_TABLE_BITS),
		.ANGLE_BITS     (ANGLE_BITS)
	) u_sine (
		.clk  (clk),
		.angle(cmd.electrical_angle),
		.sin_v(sin_v),
		.cos_v(cos_v)
	);

	always_ff @(posedge clk) begin
		vq_s1 <= cmd.voltage_q;
		vd_s1 <= cmd.voltage_d;
	end

	// s2: four rotation products
	logic               v_s2;
	logic signed [31:0] p_qs_s2;
	logic signed [31:0] p_dc_s2;
	logic signed [31:0] p_qc_s2;
	logic signed [31:0] p_ds_s2;

	always_ff @(posedge clk) begin
		p_qs_s2 <= vq_s1 * sin_v;
		p_dc_s2 <= vd_s1 * cos_v;
		p_qc_s2 <= vq_s1 * cos_v;
		p_ds_s2 <= vd_s1 * sin_v;
	end

	// s3: inverse Park, alpha/beta in volts * Q15
	logic                  v_s3;
	logic signed [AB_W-1:0] alpha_s3;
	logic signed [AB_W-1:0] beta_s3;

	always_ff @(posedge clk) begin
		alpha_s3 <= AB_W'(p_dc_s2) - AB_W'(p_qs_s2);
		beta_s3  <= AB_W'(p_qc_s2) + AB_W'(p_ds_s2);
	end

	// s4: sqrt3/2 * alpha, beta/2 (floor)
	logic                   v_s4;
	logic signed [KA_W-1:0] kap_s4;
	logic signed [AB_W-1:0] hb_s4;
	logic signed [AB_W-1:0] beta_s4;

	always_ff @(posedge clk) begin
		kap_s4  <= alpha_s3 * SQRT3_HALF_Q15;
		hb_s4   <= beta_s3 >>> 1;
		beta_s4 <= beta_s3;
	end

	// s5: the two mixed differences
	logic                  v_s5;
	logic signed [D_W-1:0] d2_s5;
	logic signed [D_W-1:0] d3_s5;
	logic signed [AB_W-1:0] beta_s5;
	logic signed [D_W-1:0] ka;

	assign ka = $signed(kap_s4[KA_W-1:15]);

	always_ff @(posedge clk) begin
		d2_s5   <= ka - D_W'(hb_s4);
		d3_s5   <= -ka - D_W'(hb_s4);
		beta_s5 <= beta_s4;
	end

	// s6: gain products
	logic                  v_s6;
	logic signed [P_W-1:0] m1_s6;
	logic signed [P_W-1:0] m2_s6;
	logic signed [P_W-1:0] m3_s6;
	logic signed [G_W-1:0] gain_sx;

	assign gain_sx = $signed({1'b0, gain});

	always_ff @(posedge clk) begin
		m1_s6 <= beta_s5 * gain_sx;
		m2_s6 <= d2_s5 * gain_sx;
		m3_s6 <= d3_s5 * gain_sx;
	end

	// s7: sector from sign tests, active times
	logic                  v_s7;
	logic [2:0]            sec_s7;
	logic [T_W-1:0]        tx_s7;
	logic [T_W-1:0]        ty_s7;
	logic signed [U_W-1:0] u1;
	logic signed [U_W-1:0] u2;
	logic signed [U_W-1:0] u3;
	logic [2:0]            code;
	logic [2:0]            sec_n;
	logic signed [U_W-1:0] tx_n;
	logic signed [U_W-1:0] ty_n;

	assign u1   = $signed(m1_s6[P_W-1:16]);
	assign u2   = $signed(m2_s6[P_W-1:16]);
	assign u3   = $signed(m3_s6[P_W-1:16]);
	assign code = {!u3[U_W-1] && (|u3), !u2[U_W-1] && (|u2), !u1[U_W-1] && (|u1)};

	always_comb begin
		case (code)
			3'b011: begin
				sec_n = SECT_1; tx_n = u2;  ty_n = u1;
			end
			3'b001: begin
				sec_n = SECT_2; tx_n = -u2; ty_n = -u3;
			end
			3'b101: begin
				sec_n = SECT_3; tx_n = u1;  ty_n = u3;
			end
			3'b100: begin
				sec_n = SECT_4; tx_n = -u1; ty_n = -u2;
			end
			3'b110: begin
				sec_n = SECT_5; tx_n = u3;  ty_n = u2;
			end
			3'b010: begin
				sec_n = SECT_6; tx_n = -u3; ty_n = -u1;
			end
			// zero vector, or all three positive from rounding
			default: begin
				sec_n = SECT_NONE; tx_n = '0; ty_n = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		sec_s7 <= sec_n;
		tx_s7  <= T_W'(tx_n);
		ty_s7  <= T_W'(ty_n);
	end

	// s8: sum and overmodulation test
	logic           v_s8;
	logic [T_W-1:0] sum_s8;
	logic [T_W-1:0] tx_s8;
	logic [T_W-1:0] ty_s8;
	side_t          side_s8;
	logic [T_W-1:0] sum_n;

	assign sum_n = tx_s7 + ty_s7;

	always_ff @(posedge clk) begin
		sum_s8       <= sum_n;
		tx_s8        <= tx_s7;
		ty_s8        <= ty_s7;
		side_s8.sec  <= sec_s7;
		side_s8.ovm  <= (sec_s7 != SECT_NONE) && (sum_n > T_W'(ONE_Q15));
		side_s8.tx   <= tx_s7[Q_W-1:0];
		side_s8.ty   <= ty_s7[Q_W-1:0];
	end

	// s9..s24: t * 32768 / sum, always run, used only when overmodulated
	logic           v_s24;
	logic [Q_W-1:0] qx_s24;
	logic [Q_W-1:0] qy_s24;
	side_t          side_s24;

	svd_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_in  (v_s8),
		.num_x   (tx_s8),
		.num_y   (ty_s8),
		.den     (sum_s8),
		.side_in (side_s8),
		.vld_out (v_s24),
		.q_x     (qx_s24),
		.q_y     (qy_s24),
		.side_out(side_s24)
	);

	// s25: final times and zero-vector half
	logic        v_s25;
	logic [16:0] tx_s25;
	logic [16:0] ty_s25;
	logic [16:0] t7_s25;
	logic [2:0]  sec_s25;
	logic        ovm_s25;
	logic [16:0] txf;
	logic [16:0] tyf;
	logic [16:0] t0;

	assign txf = {1'b0, side_s24.ovm ? qx_s24 : side_s24.tx};
	assign tyf = {1'b0, side_s24.ovm ? qy_s24 : side_s24.ty};
	assign t0  = ONE_Q15 - txf - tyf;

	always_ff @(posedge clk) begin
		tx_s25  <= txf;
		ty_s25  <= tyf;
		t7_s25  <= t0 >> 1;
		sec_s25 <= side_s24.sec;
		ovm_s25 <= side_s24.ovm;
	end

	// s26: phase duties per sector
	logic        v_s26;
	logic [16:0] da_s26;
	logic [16:0] db_s26;
	logic [16:0] dc_s26;
	logic [2:0]  sec_s26;
	logic        ovm_s26;
	logic [16:0] d_all;
	logic [16:0] d_y;
	logic [16:0] da_n;
	logic [16:0] db_n;
	logic [16:0] dc_n;

	assign d_all = tx_s25 + ty_s25 + t7_s25;
	assign d_y   = ty_s25 + t7_s25;

	always_comb begin
		case (sec_s25)
			SECT_1: begin
				da_n = d_all;  db_n = d_y;    dc_n = t7_s25;
			end
			SECT_2: begin
				da_n = d_y;    db_n = d_all;  dc_n = t7_s25;
			end
			SECT_3: begin
				da_n = t7_s25; db_n = d_all;  dc_n = d_y;
			end
			SECT_4: begin
				da_n = t7_s25; db_n = d_y;    dc_n = d_all;
			end
			SECT_5: begin
				da_n = d_y;    db_n = t7_s25; dc_n = d_all;
			end
			SECT_6: begin
				da_n = d_all;  db_n = t7_s25; dc_n = d_y;
			end
			default: begin
				da_n = HALF_Q15; db_n = HALF_Q15; dc_n = HALF_Q15;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		da_s26  <= da_n;
		db_s26  <= db_n;
		dc_s26  <= dc_n;
		sec_s26 <= sec_s25;
		ovm_s26 <= ovm_s25;
	end

	// s27: compare counts = duty * period >> 15, output register
	logic        v_s27;
	res_t        res_s27;
	logic [32:0] pa;
	logic [32:0] pb;
	logic [32:0] pc;

	assign pa = da_s26 * period;
	assign pb = db_s26 * period;
	assign pc = dc_s26 * period;

	always_ff @(posedge clk) begin
		res_s27.compare_a     <= pa[30:15];
		res_s27.compare_b     <= pb[30:15];
		res_s27.compare_c     <= pc[30:15];
		res_s27.sector_number <= sec_s26;
		res_s27.overmodulated <= ovm_s26;
	end

	// valid chain outside the divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s25 <= 1'b0;
			v_s26 <= 1'b0;
			v_s27 <= 1'b0;
		end else begin
			v_s1  <= start & ~busy;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s25 <= v_s24;
			v_s26 <= v_s25;
			v_s27 <= v_s26;
		end
	end

	assign done = v_s27;
	assign res  = res_s27;

endmodule

/* hw/rtl/svd_cfg.sv */
module svd_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [svd_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic [23:0]                 gain,
	output logic [15:0]                 period
);
	import svd_pkg::*;

	logic [23:0] gain_q;
	logic [15:0] period_q;
	logic        wr_en;

	assign wr_en = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q   <= GAIN_RST;
			period_q <= PERIOD_RST;
		end else if (wr_en) begin
			case (paddr[2])
				REG_GAIN:   gain_q   <= pwdata[23:0];
				REG_PERIOD: period_q <= pwdata[15:0];
				default:    gain_q   <= gain_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_GAIN:   prdata = {8'd0, gain_q};
			REG_PERIOD: prdata = {16'd0, period_q};
			default:    prdata = 32'd0;
		endcase
	end

	assign gain   = gain_q;
	assign period = period_q;

endmodule

/* hw/rtl/svd_sine.sv */
module svd_sine #(
	parameter int SINE_TABLE_BITS = svd_pkg::SINE_TABLE_BITS_DEF,
	parameter int ANGLE_BITS      = svd_pkg::ANGLE_BITS_DEF
) (
	input  logic               clk,
	input  logic [15:0]        angle,
	output logic signed [15:0] sin_v,
	output logic signed [15:0] cos_v
);
	import svd_pkg::*;

	localparam int TB = SINE_TABLE_BITS;
	localparam int QB = TB - 2;
	localparam int QN = 1 << QB;

	logic [ANGLE_BITS-1:0] ang_w;
	logic [TB-1:0]         idx_s;
	logic [TB-1:0]         idx_c;
	logic [QB:0]           pos_s;
	logic [QB:0]           pos_c;
	logic [14:0]           rom [QN];
	logic [14:0]           mag_s_s1;
	logic [14:0]           mag_c_s1;
	logic                  neg_s_s1;
	logic                  neg_c_s1;

	if (ANGLE_BITS >= 16) begin : g_awide
		assign ang_w = {{(ANGLE_BITS - 16){1'b0}}, angle};
	end else begin : g_anarrow
		assign ang_w = angle[ANGLE_BITS-1:0];
	end

	if (ANGLE_BITS >= TB) begin : g_idn
		assign idx_s = ang_w[ANGLE_BITS-1 -: TB];
	end else begin : g_iup
		assign idx_s = {ang_w, {(TB - ANGLE_BITS){1'b0}}};
	end

	// cos = sin a quarter turn ahead
	assign idx_c = idx_s + TB'(QN);

	// mirror odd quadrants; pos runs 0..QN inclusive
	assign pos_s = idx_s[QB] ? (QB+1)'(QN) - {1'b0, idx_s[QB-1:0]} : {1'b0, idx_s[QB-1:0]};
	assign pos_c = idx_c[QB] ? (QB+1)'(QN) - {1'b0, idx_c[QB-1:0]} : {1'b0, idx_c[QB-1:0]};

	always_comb begin
		for (int i = 0; i < QN; i++) begin
			rom[i] = sine_q15(i, QB);
		end
	end

	// top of the quarter saturates at 32767
	always_ff @(posedge clk) begin
		mag_s_s1 <= pos_s[QB] ? 15'h7fff : rom[pos_s[QB-1:0]];
		mag_c_s1 <= pos_c[QB] ? 15'h7fff : rom[pos_c[QB-1:0]];
		neg_s_s1 <= idx_s[TB-1];
		neg_c_s1 <= idx_c[TB-1];
	end

	assign sin_v = neg_s_s1 ? -$signed({1'b0, mag_s_s1}) : $signed({1'b0, mag_s_s1});
	assign cos_v = neg_c_s1 ? -$signed({1'b0, mag_c_s1}) : $signed({1'b0, mag_c_s1});

endmodule

/* hw/rtl/svd_div.sv */
module svd_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      vld_in,
	input  logic [svd_pkg::T_W-1:0]   num_x,
	input  logic [svd_pkg::T_W-1:0]   num_y,
	input  logic [svd_pkg::T_W-1:0]   den,
	input  svd_pkg::side_t            side_in,
	output logic                      vld_out,
	output logic [svd_pkg::Q_W-1:0]   q_x,
	output logic [svd_pkg::Q_W-1:0]   q_y,
	output svd_pkg::side_t            side_out
);
	import svd_pkg::*;

	// restoring division, one quotient bit per stage, MSB first
	localparam int NST = Q_W;

	logic [NST-1:0]  v_s;
	logic [DV_W-1:0] rx_s  [NST];
	logic [DV_W-1:0] ry_s  [NST];
	logic [Q_W-1:0]  qx_s  [NST];
	logic [Q_W-1:0]  qy_s  [NST];
	logic [DV_W-1:0] den_s [NST];
	side_t           sd_s  [NST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			v_s <= {v_s[NST-2:0], vld_in};
		end
	end

	for (genvar k = 0; k < NST; k++) begin : g_st
		logic [DV_W-1:0] rx_in;
		logic [DV_W-1:0] ry_in;
		logic [DV_W-1:0] dn;
		logic [Q_W-1:0]  qx_in;
		logic [Q_W-1:0]  qy_in;
		side_t           sd;
		logic            gx;
		logic            gy;

		if (k == 0) begin : g_first
			assign rx_in = {1'b0, num_x};
			assign ry_in = {1'b0, num_y};
			assign dn    = {1'b0, den};
			assign qx_in = '0;
			assign qy_in = '0;
			assign sd    = side_in;
		end else begin : g_next
			assign rx_in = {rx_s[k-1][DV_W-2:0], 1'b0};
			assign ry_in = {ry_s[k-1][DV_W-2:0], 1'b0};
			assign dn    = den_s[k-1];
			assign qx_in = qx_s[k-1];
			assign qy_in = qy_s[k-1];
			assign sd    = sd_s[k-1];
		end

		assign gx = rx_in >= dn;
		assign gy = ry_in >= dn;

		always_ff @(posedge clk) begin
			rx_s[k]  <= gx ? rx_in - dn : rx_in;
			ry_s[k]  <= gy ? ry_in - dn : ry_in;
			qx_s[k]  <= {qx_in[Q_W-2:0], gx};
			qy_s[k]  <= {qy_in[Q_W-2:0], gy};
			den_s[k] <= dn;
			sd_s[k]  <= sd;
		end
	end

	assign vld_out  = v_s[NST-1];
	assign q_x      = qx_s[NST-1];
	assign q_y      = qy_s[NST-1];
	assign side_out = sd_s[NST-1];

endmodule

/* hw/rtl/svd_chk.sv */
module svd_chk (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          done,
	input svd_pkg::res_t res
);
	import svd_pkg::*;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LAT done)
		else $error("result beat missing after command");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result beat without command");

	a_zero_sector: assert property (@(posedge clk) disable iff (!arst_n)
		done && res.sector_number == SECT_NONE |->
			!res.overmodulated && res.compare_a == res.compare_b
			&& res.compare_b == res.compare_c)
		else $error("zero vector result not balanced");

	a_sector_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> res.sector_number != 3'd7)
		else $error("sector out of range");

endmodule

bind svpwm_duty_generator_core svd_chk u_svd_chk (.*);

/* sim/testbench.sv */
module testbench;
	import svd_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	// Expected duty results for accepted voltage commands.
	class duty_scoreboard;
		logic [23:0] gain;
		logic [15:0] period;
		res_t        duty_q[$];
		int          errors;

		function new();
			gain   = GAIN_RST;
			period = PERIOD_RST;
			errors = 0;
		endfunction

		// quarter-wave polynomial sine, 1024 entries per turn
		function longint sine_at(int unsigned idx);
			int unsigned quad;
			int unsigned r;
			int unsigned pos;
			longint x;
			longint x2;
			longint y;
			idx  = idx & 1023;
			quad = idx >> 8;
			r    = idx & 255;
			pos  = quad[0] ? 256 - r : r;
			x    = longint'(pos) << 7;
			x2   = (x * x) >> 15;
			y    = (x * (51472 - ((x2 * (21024 - ((x2 * 2320) >> 15))) >> 15))) >> 15;
			if (y > 32767) begin
				y = 32767;
			end
			return quad[1] ? -y : y;
		endfunction

		function logic [15:0] to_count(longint duty);
			longint prod;
			if (duty < 0) begin
				duty = 0;
			end
			prod = (duty * longint'(period)) >>> 15;
			return prod[15:0];
		endfunction

		function void note_command(cmd_t c);
			longint vq, vd, s, co, alpha, beta, ka, hb, g, u1, u2, u3;
			longint tx, ty, t7, total, da, db, dc;
			int unsigned idx;
			logic [2:0] code;
			logic [2:0] sect;
			logic ovm;
			res_t r;
			vq    = longint'(c.voltage_q);
			vd    = longint'(c.voltage_d);
			idx   = c.electrical_angle >> 6;
			s     = sine_at(idx);
			co    = sine_at(idx + 256);
			alpha = -vq * s + vd * co;
			beta  = vq * co + vd * s;
			g     = longint'(gain);
			ka    = (28378 * alpha) >>> 15;
			hb    = beta >>> 1;
			u1    = (beta * g) >>> 16;
			u2    = ((ka - hb) * g) >>> 16;
			u3    = ((-ka - hb) * g) >>> 16;
			code  = {u3 > 0, u2 > 0, u1 > 0};
			tx    = 0;
			ty    = 0;
			ovm   = 1'b0;
			case (code)
				3'd3: begin sect = SECT_1; tx = u2;  ty = u1;  end
				3'd1: begin sect = SECT_2; tx = -u2; ty = -u3; end
				3'd5: begin sect = SECT_3; tx = u1;  ty = u3;  end
				3'd4: begin sect = SECT_4; tx = -u1; ty = -u2; end
				3'd6: begin sect = SECT_5; tx = u3;  ty = u2;  end
				3'd2: begin sect = SECT_6; tx = -u3; ty = -u1; end
				default: sect = SECT_NONE;
			endcase
			if (sect == SECT_NONE) begin
				da = 16384;
				db = 16384;
				dc = 16384;
			end else begin
				total = tx + ty;
				if (total > 32768) begin
					tx  = (tx * 32768) / total;
					ty  = (ty * 32768) / total;
					ovm = 1'b1;
				end
				t7 = (32768 - tx - ty) >>> 1;
				case (sect)
					SECT_1: begin da = tx + ty + t7; db = ty + t7; dc = t7; end
					SECT_2: begin da = ty + t7; db = tx + ty + t7; dc = t7; end
					SECT_3: begin da = t7; db = tx + ty + t7; dc = ty + t7; end
					SECT_4: begin da = t7; db = ty + t7; dc = tx + ty + t7; end
					SECT_5: begin da = ty + t7; db = t7; dc = tx + ty + t7; end
					default: begin da = tx + ty + t7; db = t7; dc = ty + t7; end
				endcase
			end
			r.compare_a     = to_count(da);
			r.compare_b     = to_count(db);
			r.compare_c     = to_count(dc);
			r.sector_number = sect;
			r.overmodulated = ovm;
			duty_q.push_back(r);
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (duty_q.size() == 0) begin
				$error("result with nothing expected: %h", got);
				errors++;
				return;
			end
			want = duty_q.pop_front();
			if (got.compare_a != want.compare_a) begin
				$error("compare_a expected %0d got %0d", want.compare_a, got.compare_a);
				errors++;
			end
			if (got.compare_b != want.compare_b) begin
				$error("compare_b expected %0d got %0d", want.compare_b, got.compare_b);
				errors++;
			end
			if (got.compare_c != want.compare_c) begin
				$error("compare_c expected %0d got %0d", want.compare_c, got.compare_c);
				errors++;
			end
			if (got.sector_number != want.sector_number) begin
				$error("sector_number expected %0d got %0d", want.sector_number,
					got.sector_number);
				errors++;
			end
			if (got.overmodulated != want.overmodulated) begin
				$error("overmodulated expected %0d got %0d", want.overmodulated,
					got.overmodulated);
				errors++;
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	cmd_t                cmd;
	logic                done;
	res_t                res;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;

	duty_scoreboard sb;
	int             cycles;
	int             idle_pct;

	svpwm_duty_generator_core u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.cmd     (cmd),
		.done    (done),
		.res     (res),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// command beats and result beats, both sampled at the edge that takes them
	always @(posedge clk) begin
		if (arst_n && start && !busy) begin
			sb.note_command(cmd);
		end
		if (arst_n && done) begin
			sb.check_result(res);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic send_command(cmd_t c);
		logic taken;
		if (idle_pct > 0) begin
			while ($urandom_range(99) < idle_pct) begin
				start <= 1'b0;
				@(posedge clk);
			end
		end
		start <= 1'b1;
		cmd   <= c;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end
	endtask

	task automatic send_voltage(int q, int d, int unsigned ang);
		cmd_t c;
		c.voltage_q        = q[15:0];
		c.voltage_d        = d[15:0];
		c.electrical_angle = ang[15:0];
		send_command(c);
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.duty_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (LAT + 4) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] value);
		logic ok;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'({idx, 2'b00});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		ok = 1'b0;
		while (!ok) begin
			@(negedge clk);
			ok = pready;
			@(posedge clk);
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == REG_GAIN) begin
			sb.gain = value[23:0];
		end else begin
			sb.period = value[15:0];
		end
	endtask

	// mix: tiny, medium and full-range vectors, and some with raw random fields
	task automatic random_burst(int count);
		int sel;
		int mag;
		repeat (count) begin
			sel = $urandom_range(9);
			mag = (sel < 4) ? 16 : (sel < 7) ? 512 : 32768;
			if (sel == 9) begin
				send_voltage($urandom, $urandom, $urandom);
			end else begin
				send_voltage($urandom_range(2 * mag - 1) - mag,
					$urandom_range(2 * mag - 1) - mag, $urandom_range(65535));
			end
		end
	endtask

	initial begin
		sb       = new();
		cycles   = 0;
		idle_pct = 24;
		arst_n   = 1'b0;
		start    = 1'b0;
		cmd      = '0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero vector, field extremes, two points in each sector
		send_voltage(0, 0, 0);
		send_voltage(0, 0, 16'hFFFF);
		send_voltage(-32768, -32768, 0);
		send_voltage(32767, 32767, 16'hFFFF);
		send_voltage(32767, -32768, 16'h8000);
		send_voltage(-32768, 32767, 16'h4000);
		for (int k = 0; k < 12; k++) begin
			send_voltage(0, 3, k * 5461 + 2000);
		end
		send_voltage(1, 0, 16'hC000);
		send_voltage(0, -1, 16'h2AAA);
		random_burst(200);
		drain();

		// gain of zero: every vector collapses to the zero sector
		write_reg(REG_GAIN, 32'd0);
		send_voltage(32767, 100, 16'h1234);
		random_burst(60);
		drain();

		// smallest gain keeps large commands linear; no idling here
		idle_pct = 0;
		write_reg(REG_GAIN, 32'd1);
		write_reg(REG_PERIOD, 32'd65535);
		random_burst(300);
		drain();
		idle_pct = 24;

		// largest gain: nearly everything overmodulates
		write_reg(REG_GAIN, 32'hFFFFFF);
		random_burst(200);
		drain();

		write_reg(REG_GAIN, 32'd40);
		write_reg(REG_PERIOD, 32'd1);
		random_burst(200);
		drain();

		// period zero forces zero counts
		write_reg(REG_PERIOD, 32'd0);
		random_burst(80);
		drain();

		write_reg(REG_GAIN, 32'd300);
		write_reg(REG_PERIOD, 32'd12345);
		random_burst(260);
		drain();

		write_reg(REG_GAIN, 32'd9155);
		write_reg(REG_PERIOD, 32'd280);
		random_burst(280);
		drain();

		if (sb.errors == 0 && sb.duty_q.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule

/* files.f */
hw/rtl/svd_pkg.sv
hw/rtl/svd_cfg.sv
hw/rtl/svd_sine.sv
hw/rtl/svd_div.sv
hw/rtl/svpwm_duty_generator_core.sv
hw/rtl/svd_chk.sv
sim/testbench.sv
